>>> sv/circular_deque_defines.svh
// Assertion macros shared by the deque RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle check: when ante holds, cons must hold too.
`define CDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/cdq_pkg.sv
// Shared types and constants for the deque: operation codes, row commands
// and the link record passed between neighboring cells. No dependencies.
package cdq_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    // Command broadcast to every cell of one row.
    typedef enum logic [2:0] {
        ROW_HOLD   = 3'd0,
        ROW_INSERT = 3'd1,
        ROW_REMOVE = 3'd2,
        ROW_APPEND = 3'd3,
        ROW_TRIM   = 3'd4,
        ROW_CLEAR  = 3'd5
    } row_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } cell_link_t;

endpackage

>>> sv/cdq_cell.sv
// One storage cell of a deque row: a data word and a valid bit, updated
// from its own state and its two neighbors. Depends on cdq_pkg.
module cdq_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cdq_pkg::row_cmd_t         cmd,
    input  logic [cdq_pkg::DATA_W-1:0] push_data,
    input  cdq_pkg::cell_link_t       left,
    input  cdq_pkg::cell_link_t       right,
    output cdq_pkg::cell_link_t       self
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [cdq_pkg::DATA_W-1:0] data_reg;
    logic [cdq_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (cmd)
            cdq_pkg::ROW_INSERT:
            begin
                valid_next = left.valid;
                data_next  = left.data;
            end
            cdq_pkg::ROW_REMOVE:
            begin
                valid_next = right.valid;
                data_next  = right.data;
            end
            cdq_pkg::ROW_APPEND:
            begin
                // first empty cell takes the new word
                if (!valid_reg && left.valid)
                begin
                    valid_next = 1'b1;
                    data_next  = push_data;
                end
            end
            cdq_pkg::ROW_TRIM:
            begin
                // last occupied cell drops out
                if (valid_reg && !right.valid)
                begin
                    valid_next = 1'b0;
                end
            end
            cdq_pkg::ROW_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign self.valid = valid_reg;
    assign self.data  = data_reg;

endmodule

>>> sv/cdq_row.sv
// A row of DEPTH cells kept packed toward cell 0, so cell 0 always holds
// the end element of the row. Depends on cdq_pkg and cdq_cell.
module cdq_row
#(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cdq_pkg::row_cmd_t          cmd,
    input  logic [cdq_pkg::DATA_W-1:0] push_data,
    output cdq_pkg::cell_link_t        head,
    output logic                       full
);

    cdq_pkg::cell_link_t cells [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cdq_pkg::cell_link_t left_link;
            cdq_pkg::cell_link_t right_link;

            if (i == 0)
            begin : g_first
                assign left_link.valid = 1'b1;
                assign left_link.data  = push_data;
            end
            else
            begin : g_mid_left
                assign left_link = cells[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_link = '0;
            end
            else
            begin : g_mid_right
                assign right_link = cells[i+1];
            end

            cdq_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .push_data (push_data),
                .left      (left_link),
                .right     (right_link),
                .self      (cells[i])
            );
        end
    endgenerate

    assign head = cells[0];
    assign full = cells[DEPTH-1].valid;

endmodule

>>> sv/circular_deque.sv
// Top level of the double-ended queue: two mirrored cell rows, fill count
// and result register. Depends on cdq_pkg, cdq_row and circular_deque_defines.svh.
//
//  channel | dir | sideband                          | payload
//  s_*     | in  | s_tuser: operation[2:0]           | s_tdata: value[31:0]
//  m_*     | out | m_tuser: ok                       | m_tdata: popped_value, fill_count
//
// One request per cycle while s_tready is high; its result appears in the cycle after acceptance.
// Every operation updates all cells of both rows at once, so the
// rate is set by the result register alone.
// Reset clears the valid bits, the fill count and the result valid flag.
// s_tready drops only while a result waits and m_tready is low.
`include "circular_deque_defines.svh"

module circular_deque
#(
    parameter int  DEPTH = cdq_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((cdq_pkg::DATA_W + CNT_W + 7) / 8) * 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [cdq_pkg::DATA_W-1:0] s_tdata,   // value
    input  logic [cdq_pkg::OP_W-1:0]   s_tuser,   // operation
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_W-1:0]           m_tdata,   // popped_value, fill_count, zero pad
    output logic                       m_tuser    // ok
);

    // front row: cell 0 is the front element; rear row: cell 0 is the rear one
    cdq_pkg::row_cmd_t          front_cmd;
    cdq_pkg::row_cmd_t          rear_cmd;
    cdq_pkg::cell_link_t        front_head;
    cdq_pkg::cell_link_t        rear_head;
    logic                       front_full;
    logic                       rear_full;

    logic                       s_accept;
    logic                       full;
    logic                       empty;
    cdq_pkg::op_t               op;
    logic                       ok;
    logic [cdq_pkg::DATA_W-1:0] popped;

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       out_valid_reg;
    logic [cdq_pkg::DATA_W-1:0] popped_reg;
    logic                       ok_reg;
    logic [CNT_W-1:0]           fill_reg;

    logic                       rows_agree;
    logic                       pop_take;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign op       = cdq_pkg::op_t'(s_tuser);
    assign full     = front_full;
    assign empty    = !front_head.valid;

    always_comb
    begin
        front_cmd  = cdq_pkg::ROW_HOLD;
        rear_cmd   = cdq_pkg::ROW_HOLD;
        ok         = 1'b0;
        popped     = '0;
        count_next = count_reg;
        case (op)
            cdq_pkg::OP_PUSH_FRONT:
            begin
                if (!full)
                begin
                    front_cmd  = cdq_pkg::ROW_INSERT;
                    rear_cmd   = cdq_pkg::ROW_APPEND;
                    ok         = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            cdq_pkg::OP_PUSH_REAR:
            begin
                if (!full)
                begin
                    front_cmd  = cdq_pkg::ROW_APPEND;
                    rear_cmd   = cdq_pkg::ROW_INSERT;
                    ok         = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            cdq_pkg::OP_POP_FRONT:
            begin
                if (!empty)
                begin
                    front_cmd  = cdq_pkg::ROW_REMOVE;
                    rear_cmd   = cdq_pkg::ROW_TRIM;
                    ok         = 1'b1;
                    popped     = front_head.data;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            cdq_pkg::OP_POP_REAR:
            begin
                if (!empty)
                begin
                    front_cmd  = cdq_pkg::ROW_TRIM;
                    rear_cmd   = cdq_pkg::ROW_REMOVE;
                    ok         = 1'b1;
                    popped     = rear_head.data;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            cdq_pkg::OP_CLEAR:
            begin
                front_cmd  = cdq_pkg::ROW_CLEAR;
                rear_cmd   = cdq_pkg::ROW_CLEAR;
                ok         = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        // hold both rows unless a request is taken this cycle
        if (!s_accept)
        begin
            front_cmd  = cdq_pkg::ROW_HOLD;
            rear_cmd   = cdq_pkg::ROW_HOLD;
            count_next = count_reg;
        end
    end

    cdq_row #(.DEPTH(DEPTH)) u_front_row
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (front_cmd),
        .push_data (s_tdata),
        .head      (front_head),
        .full      (front_full)
    );

    cdq_row #(.DEPTH(DEPTH)) u_rear_row
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (rear_cmd),
        .push_data (s_tdata),
        .head      (rear_head),
        .full      (rear_full)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (s_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            popped_reg <= popped;
            ok_reg     <= ok;
            fill_reg   <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({fill_reg, popped_reg});
    assign m_tuser  = ok_reg;

    assign rows_agree = (front_head.valid == rear_head.valid) && (front_full == rear_full);
    assign pop_take   = s_accept && (op == cdq_pkg::OP_POP_FRONT) && !empty;

    `CDQ_ASSERT_NOW(a_rows_agree, 1'b1, rows_agree, "rows disagree on occupancy")
    `CDQ_ASSERT_NOW(a_count_empty, 1'b1, (count_reg == '0) == empty, "count disagrees with rows")
    `CDQ_ASSERT_NEXT(a_pop_front, pop_take, popped_reg == $past(front_head.data), "bad pop word")
    `CDQ_ASSERT_NEXT(a_result_follows, s_accept, m_tvalid, "request produced no result")

endmodule

>>> tb/testbench.sv
// Self-checking bench for circular_deque: random push/pop/clear requests with a
// built-in deque predictor and in-order result checks. Depends on cdq_pkg and
// the circular_deque RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int DATA_W       = cdq_pkg::DATA_W;
    localparam int OP_W         = cdq_pkg::OP_W;
    localparam int DEQUE_DEPTH  = cdq_pkg::DEPTH_DEF;
    localparam int CNT_W        = $clog2(DEQUE_DEPTH + 1);
    localparam int OUT_W        = ((DATA_W + CNT_W + 7) / 8) * 8;
    localparam int ITEM_TARGET  = 1800;
    localparam int MAX_GAP      = 11;
    localparam int LONG_STALL   = 400;
    localparam int STALL_AT_A   = 300;
    localparam int STALL_AT_B   = 1100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 10;

    // Highest code the operation field can carry; codes above OP_CLEAR are unused.
    localparam logic [OP_W-1:0] OP_CODE_LAST = '1;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        int unsigned       gap;
        bit                drain;
    } deque_req_t;

    typedef struct {
        logic [DATA_W-1:0] popped;
        logic              ok;
        logic [CNT_W-1:0]  fill;
    } deque_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata = '0;     // value
    logic [OP_W-1:0]    s_tuser = '0;     // operation
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;          // popped_value, fill_count, zero pad
    logic               m_tuser;          // ok

    circular_deque #(.DEPTH(DEQUE_DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predictor state
    logic [DATA_W-1:0] shadow_store [DEQUE_DEPTH];
    int                front_idx = 0;
    int                rear_idx = 0;
    int                held_count = 0;

    deque_req_t        pending_reqs[$];
    deque_result_t     awaited_results[$];
    deque_req_t        next_req;
    bit                have_next = 1'b0;
    int unsigned       gap_left = 0;
    bit                req_taken = 1'b0;
    bit                res_taken = 1'b0;
    int unsigned       stall_left = 0;
    int unsigned       reqs_accepted = 0;
    int unsigned       results_seen = 0;
    int unsigned       total_reqs = 0;
    int unsigned       cycle_count = 0;
    int unsigned       error_count = 0;
    bit                tx_calm = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic deque_result_t deque_apply(logic [OP_W-1:0] op,
                                                  logic [DATA_W-1:0] value);
        deque_result_t r;
        r.popped = '0;
        r.ok     = 1'b0;
        case (op)
            cdq_pkg::OP_PUSH_FRONT:
                if (held_count < DEQUE_DEPTH)
                begin
                    front_idx = (front_idx + DEQUE_DEPTH - 1) % DEQUE_DEPTH;
                    shadow_store[front_idx] = value;
                    held_count++;
                    r.ok = 1'b1;
                end
            cdq_pkg::OP_PUSH_REAR:
                if (held_count < DEQUE_DEPTH)
                begin
                    shadow_store[rear_idx] = value;
                    rear_idx = (rear_idx + 1) % DEQUE_DEPTH;
                    held_count++;
                    r.ok = 1'b1;
                end
            cdq_pkg::OP_POP_FRONT:
                if (held_count != 0)
                begin
                    r.popped = shadow_store[front_idx];
                    front_idx = (front_idx + 1) % DEQUE_DEPTH;
                    held_count--;
                    r.ok = 1'b1;
                end
            cdq_pkg::OP_POP_REAR:
                if (held_count != 0)
                begin
                    rear_idx = (rear_idx + DEQUE_DEPTH - 1) % DEQUE_DEPTH;
                    r.popped = shadow_store[rear_idx];
                    held_count--;
                    r.ok = 1'b1;
                end
            cdq_pkg::OP_CLEAR:
            begin
                front_idx  = 0;
                rear_idx   = 0;
                held_count = 0;
                r.ok       = 1'b1;
            end
            default:
                r.ok = 1'b0;
        endcase
        r.fill = held_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("MISMATCH %s: got %h, want %h (t=%0t)", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                           input bit drain);
        deque_req_t r;
        r.op    = op;
        r.value = value;
        r.gap   = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        r.drain = drain;
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    // Stimulus and end of run
    initial
    begin
        int          real_count;
        int          seg;
        int          len;
        int          n_seg;
        bit          drain;
        logic [OP_W-1:0] op;

        // Empty pops, field extremes, every operation, unused codes, clear
        add_req(cdq_pkg::OP_POP_FRONT, draw_value(), 1'b0);
        add_req(cdq_pkg::OP_POP_REAR, draw_value(), 1'b0);
        add_req(cdq_pkg::OP_PUSH_REAR, {1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
        add_req(cdq_pkg::OP_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
        add_req(cdq_pkg::OP_PUSH_REAR, '0, 1'b0);
        add_req(cdq_pkg::OP_PUSH_FRONT, '1, 1'b0);
        add_req(cdq_pkg::OP_POP_REAR, draw_value(), 1'b0);
        add_req(cdq_pkg::OP_POP_FRONT, draw_value(), 1'b0);
        for (int c = cdq_pkg::OP_CLEAR + 1; c <= OP_CODE_LAST; c++)
            add_req(c[OP_W-1:0], draw_value(), 1'b0);
        add_req(cdq_pkg::OP_CLEAR, draw_value(), 1'b0);
        add_req(cdq_pkg::OP_POP_FRONT, draw_value(), 1'b0);
        add_req(cdq_pkg::OP_PUSH_REAR, 32'h5555_AAAA, 1'b0);
        add_req(cdq_pkg::OP_PUSH_FRONT, 32'hAAAA_5555, 1'b0);
        add_req(cdq_pkg::OP_POP_FRONT, draw_value(), 1'b0);
        add_req(cdq_pkg::OP_POP_FRONT, draw_value(), 1'b0);
        add_req(cdq_pkg::OP_CLEAR, draw_value(), 1'b0);

        // Segments: fill runs, drain runs, mixed traffic and noise
        real_count = 0;
        n_seg = 0;
        while (real_count < ITEM_TARGET)
        begin
            seg     = $urandom_range(0, 9);
            len     = $urandom_range(1, 24);
            tx_calm = ($urandom_range(0, 5) == 0);
            drain   = (n_seg == 0) || ($urandom_range(0, 15) == 0);
            for (int k = 0; k < len; k++)
            begin
                if (seg <= 2)
                    op = OP_W'($urandom_range(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR));
                else if (seg <= 5)
                    op = OP_W'($urandom_range(cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR));
                else if (seg <= 7)
                    op = ($urandom_range(0, 40) == 0) ? cdq_pkg::OP_CLEAR
                         : OP_W'($urandom_range(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_POP_REAR));
                else
                    op = OP_W'($urandom_range(0, OP_CODE_LAST));
                add_req(op, draw_value(), drain && (k == 0));
                if (op <= cdq_pkg::OP_CLEAR)
                    real_count++;
            end
            n_seg++;
        end
        tx_calm = 1'b0;

        while (reqs_accepted != total_reqs || awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || req_taken)
            begin
                if (!have_next && pending_reqs.size() > 0)
                begin
                    next_req  = pending_reqs.pop_front();
                    gap_left  = next_req.gap;
                    have_next = 1'b1;
                end
                // A draining request waits until every result is back
                if (have_next && gap_left == 0 &&
                    !(next_req.drain && awaited_results.size() != 0))
                begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= next_req.value;
                    s_tuser   <= next_req.op;
                    have_next = 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    if (have_next && gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Result receiver: random stalls, calm stretches and two long hold-offs
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
            begin
                if (results_seen == STALL_AT_A || results_seen == STALL_AT_B)
                    stall_left = LONG_STALL;
                else if ((results_seen / 128) % 4 == 1)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, MAX_GAP);
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n)
        begin
            cycle_count++;
            req_taken = s_tvalid && s_tready;
            res_taken = m_tvalid && m_tready;
            if (req_taken)
            begin
                awaited_results.push_back(deque_apply(s_tuser, s_tdata));
                reqs_accepted++;
            end
            if (res_taken)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                    report_mismatch("result with no request pending",
                                    m_tdata[DATA_W-1:0], '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tdata[DATA_W-1:0] !== want.popped)
                        report_mismatch("popped_value", m_tdata[DATA_W-1:0], want.popped);
                    if (m_tuser !== want.ok)
                        report_mismatch("ok", DATA_W'(m_tuser), DATA_W'(want.ok));
                    if (m_tdata[DATA_W +: CNT_W] !== want.fill)
                        report_mismatch("fill_count", DATA_W'(m_tdata[DATA_W +: CNT_W]),
                                        DATA_W'(want.fill));
                end
            end
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
